[hw/rtl/npci_pkg.sv]
// Shared types, palette tables and helper functions for the nearest palette color index block.
package npci_pkg;

  // Channel and distance widths.
  localparam int CH_W      = 8;
  localparam int SQ_W      = 2 * CH_W;
  localparam int DIST_W    = SQ_W + 2;
  localparam int IDX_W     = 4;
  localparam int NUM_SLOTS = 16;
  localparam int NUM_PAL8  = 8;
  localparam int PAL8_W    = 3;
  localparam int GROUP_SZ  = 4;
  localparam int NUM_GRPS  = NUM_SLOTS / GROUP_SZ;

  // Distinct component levels used across the two palettes.
  localparam int NUM_LVL = 6;
  localparam int LVL_W   = 3;

  typedef logic [CH_W-1:0]   diff_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  // Larger than any real distance (3 * 255 * 255), so an unused slot never wins.
  localparam dist_t DIST_MAX = '1;

  // Named level codes.
  localparam lvl_t LVL_0   = 3'd0;
  localparam lvl_t LVL_85  = 3'd1;
  localparam lvl_t LVL_128 = 3'd2;
  localparam lvl_t LVL_170 = 3'd3;
  localparam lvl_t LVL_192 = 3'd4;
  localparam lvl_t LVL_255 = 3'd5;

  typedef struct packed {
    lvl_t r;
    lvl_t g;
    lvl_t b;
  } entry_t;

  // Absolute differences of each component against every level.
  typedef struct packed {
    logic                      sel;
    diff_t [NUM_LVL-1:0]       r;
    diff_t [NUM_LVL-1:0]       g;
    diff_t [NUM_LVL-1:0]       b;
  } diff_set_t;

  // Squared differences of each component against every level.
  typedef struct packed {
    logic                      sel;
    sq_t [NUM_LVL-1:0]         r;
    sq_t [NUM_LVL-1:0]         g;
    sq_t [NUM_LVL-1:0]         b;
  } sq_set_t;

  // Distance to every palette slot.
  typedef struct packed {
    logic                      sel;
    dist_t [NUM_SLOTS-1:0]     slot_sum;
  } dist_set_t;

  typedef struct packed {
    dist_t sq_sum;
    idx_t  idx;
  } cand_t;

  typedef cand_t [NUM_GRPS-1:0] cand_set_t;

  // Component value of a level code.
  function automatic diff_t level_value(input lvl_t lvl);
    diff_t v;
    case (lvl)
      LVL_0:   v = 8'd0;
      LVL_85:  v = 8'd85;
      LVL_128: v = 8'd128;
      LVL_170: v = 8'd170;
      LVL_192: v = 8'd192;
      LVL_255: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // The 8-color palette as level codes.
  function automatic entry_t pal8_entry(input logic [PAL8_W-1:0] idx);
    entry_t e;
    case (idx)
      3'd0:    e = '{LVL_0,   LVL_0,   LVL_0};
      3'd1:    e = '{LVL_128, LVL_0,   LVL_0};
      3'd2:    e = '{LVL_0,   LVL_128, LVL_0};
      3'd3:    e = '{LVL_128, LVL_128, LVL_0};
      3'd4:    e = '{LVL_0,   LVL_0,   LVL_128};
      3'd5:    e = '{LVL_128, LVL_0,   LVL_128};
      3'd6:    e = '{LVL_0,   LVL_128, LVL_128};
      3'd7:    e = '{LVL_192, LVL_192, LVL_192};
      default: e = '{LVL_0,   LVL_0,   LVL_0};
    endcase
    return e;
  endfunction

  // The 16-color palette as level codes.
  function automatic entry_t pal16_entry(input idx_t idx);
    entry_t e;
    case (idx)
      4'd0:    e = '{LVL_0,   LVL_0,   LVL_0};
      4'd1:    e = '{LVL_0,   LVL_0,   LVL_170};
      4'd2:    e = '{LVL_0,   LVL_170, LVL_0};
      4'd3:    e = '{LVL_0,   LVL_170, LVL_170};
      4'd4:    e = '{LVL_170, LVL_0,   LVL_0};
      4'd5:    e = '{LVL_170, LVL_0,   LVL_170};
      4'd6:    e = '{LVL_170, LVL_85,  LVL_0};
      4'd7:    e = '{LVL_170, LVL_170, LVL_170};
      4'd8:    e = '{LVL_85,  LVL_85,  LVL_85};
      4'd9:    e = '{LVL_85,  LVL_85,  LVL_255};
      4'd10:   e = '{LVL_85,  LVL_255, LVL_85};
      4'd11:   e = '{LVL_85,  LVL_255, LVL_255};
      4'd12:   e = '{LVL_255, LVL_85,  LVL_85};
      4'd13:   e = '{LVL_255, LVL_85,  LVL_255};
      4'd14:   e = '{LVL_255, LVL_255, LVL_85};
      4'd15:   e = '{LVL_255, LVL_255, LVL_255};
      default: e = '{LVL_0,   LVL_0,   LVL_0};
    endcase
    return e;
  endfunction

  // Keep the lower-index candidate unless the higher one is strictly nearer.
  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    return (hi.sq_sum < lo.sq_sum) ? hi : lo;
  endfunction

endpackage

[hw/rtl/npci_sq.sv]
// Difference and squaring stages: per-level absolute differences, then their squares.
module npci_sq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          red,
  input  logic [7:0]          green,
  input  logic [7:0]          blue,
  input  logic                sel,
  output logic                out_valid,
  input  logic                out_ready,
  output npci_pkg::sq_set_t   out_word
);

  logic                 v1;
  npci_pkg::diff_set_t  d1;
  npci_pkg::diff_set_t  d1_next;
  logic                 v2;
  npci_pkg::sq_set_t    q2;
  npci_pkg::sq_set_t    q2_next;
  logic                 ready1;
  logic                 ready2;

  // Each stage moves when it is empty or the next one takes its word.
  assign ready2   = !v2 || out_ready;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // Absolute difference of every component against every level.
  always_comb begin
    npci_pkg::diff_t lv;
    d1_next.sel = sel;
    for (int k = 0; k < npci_pkg::NUM_LVL; k++) begin
      lv = npci_pkg::level_value(npci_pkg::LVL_W'(k));
      d1_next.r[k] = (red   >= lv) ? (red   - lv) : (lv - red);
      d1_next.g[k] = (green >= lv) ? (green - lv) : (lv - green);
      d1_next.b[k] = (blue  >= lv) ? (blue  - lv) : (lv - blue);
    end
  end

  // Square of every difference.
  always_comb begin
    q2_next.sel = d1.sel;
    for (int k = 0; k < npci_pkg::NUM_LVL; k++) begin
      q2_next.r[k] = npci_pkg::sq_t'(d1.r[k]) * npci_pkg::sq_t'(d1.r[k]);
      q2_next.g[k] = npci_pkg::sq_t'(d1.g[k]) * npci_pkg::sq_t'(d1.g[k]);
      q2_next.b[k] = npci_pkg::sq_t'(d1.b[k]) * npci_pkg::sq_t'(d1.b[k]);
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
    end
  end

  // Data registers load only when a word moves in.
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) d1 <= d1_next;
    if (ready2 && v1) q2 <= q2_next;
  end

  assign out_valid = v2;
  assign out_word  = q2;

endmodule

[hw/rtl/npci_dist.sv]
// Distance stage: sums three squared differences for every palette slot.
module npci_dist (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  npci_pkg::sq_set_t     in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output npci_pkg::dist_set_t   out_word
);

  logic                 v;
  npci_pkg::dist_set_t  sums;
  npci_pkg::dist_set_t  sums_next;

  assign in_ready = !v || out_ready;

  // Slot distances; with the small palette the upper slots are parked at the maximum.
  always_comb begin
    npci_pkg::entry_t e;
    sums_next.sel = in_word.sel;
    for (int i = 0; i < npci_pkg::NUM_SLOTS; i++) begin
      if (in_word.sel) begin
        e = npci_pkg::pal16_entry(npci_pkg::IDX_W'(i));
      end else begin
        e = npci_pkg::pal8_entry(npci_pkg::PAL8_W'(i));
      end
      sums_next.slot_sum[i] = npci_pkg::dist_t'(in_word.r[e.r])
                            + npci_pkg::dist_t'(in_word.g[e.g])
                            + npci_pkg::dist_t'(in_word.b[e.b]);
      if (!in_word.sel && i >= npci_pkg::NUM_PAL8) begin
        sums_next.slot_sum[i] = npci_pkg::DIST_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) sums <= sums_next;
  end

  assign out_valid = v;
  assign out_word  = sums;

endmodule

[hw/rtl/npci_min.sv]
// Minimum search: a two-stage registered tree that keeps the lowest index on ties.
module npci_min (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  npci_pkg::dist_set_t   in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output npci_pkg::idx_t        color_index
);

  logic                  va;
  npci_pkg::cand_set_t   grp;
  npci_pkg::cand_set_t   grp_next;
  logic                  vb;
  npci_pkg::idx_t        best;
  npci_pkg::idx_t        best_next;
  logic                  ready_a;
  logic                  ready_b;

  assign ready_b  = !vb || out_ready;
  assign ready_a  = !va || ready_b;
  assign in_ready = ready_a;

  // First stage: best of each group of four slots.
  always_comb begin
    npci_pkg::cand_t c [npci_pkg::GROUP_SZ];
    for (int g = 0; g < npci_pkg::NUM_GRPS; g++) begin
      for (int k = 0; k < npci_pkg::GROUP_SZ; k++) begin
        c[k].sq_sum = in_word.slot_sum[g * npci_pkg::GROUP_SZ + k];
        c[k].idx    = npci_pkg::IDX_W'(g * npci_pkg::GROUP_SZ + k);
      end
      grp_next[g] = npci_pkg::pick(npci_pkg::pick(c[0], c[1]),
                                   npci_pkg::pick(c[2], c[3]));
    end
  end

  // Second stage: best of the four group winners.
  always_comb begin
    npci_pkg::cand_t w;
    w = npci_pkg::pick(npci_pkg::pick(grp[0], grp[1]),
                       npci_pkg::pick(grp[2], grp[3]));
    best_next = w.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ready_a) va <= in_valid;
      if (ready_b) vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) grp <= grp_next;
    if (ready_b && va) best <= best_next;
  end

  assign out_valid   = vb;
  assign color_index = best;

endmodule

[hw/rtl/nearest_palette_color_index_top.sv]
// Top level of the nearest palette color index block.
//
// Takes one RGB pixel word per cycle, unless the receiver stalls, on the
// in_valid/in_ready channel and returns the index of the nearest palette
// color on the out_valid/out_ready channel, in pixel order. Nearness is the
// squared RGB distance; on a tie the lowest index wins.
// The cfg_valid/cfg_ready channel writes palette_select (0: 8-color palette,
// 1: 16-color palette). It is always ready and should be written only while
// no pixel is in flight; each pixel carries the selection it was taken with.
// From input acceptance to output valid the word passes five register
// stages: differences, squares, slot distances, then a two-level minimum
// tree whose last stage is the output register. Throughput is one pixel per
// cycle while the receiver does not stall, set by the fully pipelined
// per-level squarers and the registered minimum tree.
// Reset (rst, synchronous) empties the pipeline and sets palette_select to 0.
// When the receiver stalls, each stage holds its word and the pipeline keeps
// filling its empty stages; input is refused only once all five are full.
module nearest_palette_color_index_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] color_index,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  logic                 palette_select;
  logic                 sq_valid;
  logic                 sq_ready;
  npci_pkg::sq_set_t    sq_word;
  logic                 dist_valid;
  logic                 dist_ready;
  npci_pkg::dist_set_t  dist_word;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      palette_select <= cfg_data;
    end
  end

  // Pipeline.
  npci_sq u_sq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .sel       (palette_select),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_word  (sq_word)
  );

  npci_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_word   (sq_word),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .out_word  (dist_word)
  );

  npci_min u_min (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dist_valid),
    .in_ready    (dist_ready),
    .in_word     (dist_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .color_index (color_index)
  );

  // An empty output stage means every stage can take a word.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused while the output stage is empty");

  // With the small palette the upper slots must never be able to win.
  a_pal8_upper_parked: assert property (@(posedge clk) disable iff (rst)
    dist_valid && !dist_word.sel |->
      dist_word.slot_sum[npci_pkg::NUM_PAL8] == npci_pkg::DIST_MAX &&
      dist_word.slot_sum[npci_pkg::NUM_SLOTS-1] == npci_pkg::DIST_MAX)
    else $error("upper slot distance not parked for the 8-color palette");

  // Reset leaves the pipeline empty.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid && !dist_valid && !sq_valid)
    else $error("pipeline holds a word after reset");

endmodule
